// ===== hw/rtl/sdspi_pkg.sv =====
// Shared types and constants for the SPI-mode SD card host engine.
package sdspi_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned BiW = $clog2(BlockBytes + 1);
  localparam logic [15:0] Cmd8Scale = 16'd1000;
  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = 2;

  typedef enum logic [2:0] {
    OpInit  = 3'd0,
    OpRead  = 3'd1,
    OpWrite = 3'd2,
    OpWdata = 3'd3,
    OpMiso  = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    KindTx   = 2'd0,
    KindRd   = 2'd1,
    KindNeed = 2'd2,
    KindDone = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StTimeout = 3'd1,
    StParam   = 3'd2,
    StBad     = 3'd3,
    StRej     = 3'd4,
    StUnsup   = 3'd5
  } status_e;

  typedef enum logic [0:0] {
    RegCmdTimeout = 1'd0,
    RegRetryLimit = 1'd1
  } reg_e;

  typedef struct packed {
    logic [2:0]  op;
    logic        drive_nz;
    logic        count_z;
    logic [31:0] sector;
    logic [15:0] count;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] value;
    logic       cs;
    logic [2:0] status;
    logic       hc;
  } res_t;

endpackage

// ===== hw/rtl/sdspi_front.sv =====
// Input classifier and item queue between front and back.
module sdspi_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         operation_i,
  input  logic [7:0]         drive_number_i,
  input  logic [31:0]        sector_i,
  input  logic [15:0]        block_count_i,
  input  logic [7:0]         data_byte_i,
  output logic               item_valid_o,
  output sdspi_pkg::item_t   item_o,
  input  logic               item_take_i
);
  import sdspi_pkg::*;

  item_t              mem_q [QDepth];
  logic [QAw-1:0]     wp_q, rp_q;
  logic [QAw:0]       cnt_q;
  item_t              in_w;
  logic               wr, rd;

  assign full = (cnt_q == (QAw+1)'(QDepth));
  assign wr = push && !full;
  assign item_valid_o = (cnt_q != '0);
  assign rd = item_take_i && item_valid_o;
  assign item_o = mem_q[rp_q];

  always_comb begin
    in_w.op       = operation_i;
    in_w.drive_nz = (drive_number_i != 8'd0);
    in_w.count_z  = (block_count_i == 16'd0);
    in_w.sector   = sector_i;
    in_w.count    = block_count_i;
    in_w.data     = data_byte_i;
  end

  always_ff @(posedge clk_i) begin
    if (wr) mem_q[wp_q] <= in_w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr) wp_q <= wp_q + 1'b1;
      if (rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QAw+1)'(wr) - (QAw+1)'(rd);
    end
  end

`ifndef NO_ASSERTIONS
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QAw+1)'(QDepth)) else $error("queue overflow");
  a_no_wr_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |=> cnt_q == $past(cnt_q) - (QAw+1)'($past(rd))) else $error("write when full");
  a_rd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd |-> cnt_q != '0) else $error("read when empty");
`endif
endmodule

// ===== hw/rtl/sdspi_back.sv =====
// Sequencer that turns queued items into result words, up to two per cycle.
module sdspi_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              item_valid_i,
  input  sdspi_pkg::item_t  item_i,
  output logic              item_take_o,
  output logic              empty,
  input  logic              pop,
  output sdspi_pkg::res_t   res_o,
  output logic              res_last_o
);
  import sdspi_pkg::*;

  typedef enum logic [20:0] {
    PIdle  = 21'd1 << 0,  PClk   = 21'd1 << 1,  PC0   = 21'd1 << 2,
    PC8    = 21'd1 << 3,  PL58   = 21'd1 << 4,  PL55  = 21'd1 << 5,
    PL41   = 21'd1 << 6,  PF58   = 21'd1 << 7,  PC16  = 21'd1 << 8,
    PRcmd  = 21'd1 << 9,  PRtok  = 21'd1 << 10, PRdat = 21'd1 << 11,
    PRcrc  = 21'd1 << 12, PWcmd  = 21'd1 << 13, PWtok = 21'd1 << 14,
    PWneed = 21'd1 << 15, PWdat  = 21'd1 << 16, PWcrc = 21'd1 << 17,
    PWresp = 21'd1 << 18, PWrej  = 21'd1 << 19, PWbusy = 21'd1 << 20
  } phase_e;

  localparam logic [BiW-1:0] BiPoll = BiW'(7);
  localparam logic [BiW-1:0] BiExtra = BiW'(8);
  localparam logic [BiW-1:0] BiTrail = BiW'(9);

  phase_e       ph_q, ph_d;
  logic [5:0]   cmd_q, cmd_d;
  logic [31:0]  arg_q, arg_d;
  logic         to_q, to_d;
  logic [BiW-1:0] bi_q, bi_d;
  logic [15:0]  poll_q, poll_d, retry_q, retry_d, blk_q, blk_d;
  logic [31:0]  badr_q, badr_d;
  logic         hc_q, hc_d;
  logic [2:0]   rbl_q, rbl_d;
  logic [15:0]  ctmo_q, rlim_q, ctmo_e, rlim_e;

  res_t         r0, r1;
  logic [1:0]   nres;

  // output queue
  res_t         oq_q [4];
  logic         ol_q [4];
  logic [1:0]   owp_q, orp_q;
  logic [2:0]   ocnt_q;
  logic         opop;

  assign ctmo_e = (ctmo_q == 16'd0) ? 16'd1 : ctmo_q;
  assign rlim_e = (rlim_q == 16'd0) ? 16'd1 : rlim_q;
  assign item_take_o = item_valid_i && (ocnt_q <= 3'd2);

  function automatic logic [7:0] frame(input logic [5:0] c, input logic [31:0] a,
                                       input logic [BiW-1:0] k);
    logic [7:0] f;
    unique case (k)
      BiW'(0): f = {2'b01, c};
      BiW'(1): f = a[31:24];
      BiW'(2): f = a[23:16];
      BiW'(3): f = a[15:8];
      BiW'(4): f = a[7:0];
      default: f = (c == 6'd8) ? 8'h87 : 8'h95;
    endcase
    return f;
  endfunction

  function automatic res_t mk(input logic [1:0] k, input logic [7:0] v, input logic cs,
                              input logic [2:0] st, input logic hc);
    res_t r;
    r.kind = k; r.value = v; r.cs = cs; r.status = st; r.hc = hc;
    return r;
  endfunction

  always_comb begin
    logic [7:0] b;
    logic [15:0] pc;
    logic [15:0] rc;
    logic [15:0] bl;
    logic [31:0] ca;
    logic exp;
    logic [BiW-1:0] bn;
    ph_d = ph_q; cmd_d = cmd_q; arg_d = arg_q; to_d = to_q; bi_d = bi_q;
    poll_d = poll_q; retry_d = retry_q; blk_d = blk_q; badr_d = badr_q;
    hc_d = hc_q; rbl_d = rbl_q;
    nres = 2'd0; r0 = '0; r1 = '0;
    b = item_i.data;
    pc = 16'd0; rc = 16'd0; bl = 16'd0; exp = 1'b0; bn = '0;
    ca = hc_q ? badr_q : (badr_q << $clog2(BlockBytes));
    if (item_take_o) begin
      unique case (item_i.op)
        OpInit: if (ph_q == PIdle) begin
          hc_d = 1'b0; ph_d = PClk; bi_d = BiW'(1);
          nres = 2'd1; r0 = mk(KindTx, 8'hFF, 1'b0, StOk, 1'b0);
        end
        OpRead, OpWrite: if (ph_q == PIdle) begin
          if (item_i.drive_nz || item_i.count_z) begin
            nres = 2'd1; r0 = mk(KindDone, 8'h00, 1'b0, StParam, hc_q);
          end else begin
            badr_d = item_i.sector; blk_d = item_i.count;
            ph_d = (item_i.op == OpRead) ? PRcmd : PWcmd;
            cmd_d = (item_i.op == OpRead) ? 6'd17 : 6'd24;
            arg_d = hc_q ? item_i.sector : (item_i.sector << $clog2(BlockBytes));
            to_d = 1'b0; rbl_d = 3'd0; poll_d = '0; bi_d = BiW'(1);
            nres = 2'd1; r0 = mk(KindTx, {2'b01, cmd_d}, 1'b1, StOk, hc_q);
          end
        end
        OpWdata: if (ph_q == PWneed) begin
          ph_d = PWdat; nres = 2'd1; r0 = mk(KindTx, b, 1'b1, StOk, hc_q);
        end
        OpMiso: begin
          unique case (ph_q)
            PClk: begin
              if (bi_q < BiW'(17)) begin
                bi_d = bi_q + 1'b1; nres = 2'd1; r0 = mk(KindTx, 8'hFF, 1'b0, StOk, hc_q);
              end else begin
                ph_d = PC0; cmd_d = 6'd0; arg_d = '0; to_d = 1'b0; rbl_d = 3'd0;
                poll_d = '0; bi_d = BiW'(1);
                nres = 2'd1; r0 = mk(KindTx, 8'h40, 1'b1, StOk, hc_q);
              end
            end
            PC0, PC8, PL58, PL55, PL41, PF58, PC16, PRcmd, PWcmd: begin
              nres = 2'd1;
              if (bi_q < BiW'(6)) begin
                r0 = mk(KindTx, frame(cmd_q, arg_q, bi_q), 1'b1, StOk, hc_q);
                bi_d = bi_q + 1'b1;
              end else if (bi_q == BiW'(6)) begin
                bi_d = BiPoll; poll_d = '0;
                if (ph_q == PC8) retry_d = '0;
                r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
              end else if (bi_q == BiPoll) begin
                if (!b[7]) begin
                  arg_d = {24'd0, b}; to_d = 1'b0;
                  if (rbl_q != 3'd0) begin
                    bi_d = BiExtra; r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
                  end else begin
                    bi_d = BiTrail; r0 = mk(KindTx, 8'hFF, 1'b0, StOk, hc_q);
                  end
                end else begin
                  pc = poll_q + 1'b1; poll_d = pc;
                  if (pc < ctmo_e) exp = 1'b0;
                  else if (ph_q != PC8) exp = 1'b1;
                  else begin
                    poll_d = '0; rc = retry_q + 1'b1; retry_d = rc;
                    exp = (rc >= Cmd8Scale);
                  end
                  if (exp) begin
                    to_d = 1'b1; bi_d = BiTrail;
                    r0 = mk(KindTx, 8'hFF, 1'b0, StOk, hc_q);
                  end else begin
                    r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
                  end
                end
              end else if (bi_q == BiExtra) begin
                if (ph_q == PF58 && rbl_q == 3'd4) hc_d = b[6];
                rbl_d = rbl_q - 1'b1;
                if (rbl_d != 3'd0) r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_d);
                else begin
                  bi_d = BiTrail; r0 = mk(KindTx, 8'hFF, 1'b0, StOk, hc_d);
                end
              end else begin
                // dispatch on the stored reply
                poll_d = '0; bi_d = BiW'(1); to_d = 1'b0;
                priority case (1'b1)
                  (ph_q == PC0): begin
                    if (to_q) begin ph_d = PIdle; r0 = mk(KindDone, 0, 0, StTimeout, hc_q); end
                    else if (arg_q[7:0] != 8'h01) begin
                      ph_d = PIdle; r0 = mk(KindDone, 0, 0, StBad, hc_q);
                    end else begin
                      ph_d = PC8; cmd_d = 6'd8; arg_d = 32'h1AA; rbl_d = 3'd4;
                    end
                  end
                  (ph_q == PC8): begin
                    if (to_q) begin ph_d = PIdle; r0 = mk(KindDone, 0, 0, StTimeout, hc_q); end
                    else if (arg_q[7:0] == 8'h01) begin
                      retry_d = '0; ph_d = PL58; cmd_d = 6'd58; arg_d = '0; rbl_d = 3'd4;
                    end else if (arg_q[7:0] == 8'h05) begin
                      ph_d = PIdle; r0 = mk(KindDone, 0, 0, StUnsup, hc_q);
                    end else begin
                      ph_d = PIdle; r0 = mk(KindDone, 0, 0, StBad, hc_q);
                    end
                  end
                  (ph_q == PL58): begin
                    ph_d = PL55; cmd_d = 6'd55; arg_d = '0; rbl_d = 3'd0;
                  end
                  (ph_q == PL55): begin
                    ph_d = PL41; cmd_d = 6'd41; arg_d = 32'h4000_0000; rbl_d = 3'd0;
                  end
                  (ph_q == PL41): begin
                    if (!to_q && arg_q[7:0] == 8'h00) begin
                      hc_d = 1'b0; ph_d = PF58; cmd_d = 6'd58; arg_d = '0; rbl_d = 3'd4;
                    end else begin
                      rc = retry_q + 1'b1; retry_d = rc;
                      if (rc >= rlim_e) begin
                        ph_d = PIdle; r0 = mk(KindDone, 0, 0, StTimeout, hc_q);
                      end else begin
                        ph_d = PL58; cmd_d = 6'd58; arg_d = '0; rbl_d = 3'd4;
                      end
                    end
                  end
                  (ph_q == PF58): begin
                    ph_d = PC16; cmd_d = 6'd16; arg_d = 32'(BlockBytes); rbl_d = 3'd0;
                  end
                  (ph_q == PC16): begin
                    ph_d = PIdle;
                    r0 = mk(KindDone, 0, 0, to_q ? StTimeout :
                            (arg_q[7:0] != 8'h00 ? StBad : StOk), hc_q);
                  end
                  default: begin
                    if (to_q) begin ph_d = PIdle; r0 = mk(KindDone, 0, 0, StTimeout, hc_q); end
                    else if (arg_q[7:0] != 8'h00) begin
                      ph_d = PIdle; r0 = mk(KindDone, 0, 0, StBad, hc_q);
                    end else if (ph_q == PRcmd) begin
                      ph_d = PRtok; r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
                    end else begin
                      ph_d = PWtok; r0 = mk(KindTx, 8'hFE, 1'b1, StOk, hc_q);
                    end
                  end
                endcase
                if (ph_d == PC8 || ph_d == PL58 || ph_d == PL55 || ph_d == PL41 ||
                    ph_d == PF58 || ph_d == PC16)
                  r0 = mk(KindTx, {2'b01, cmd_d}, 1'b1, StOk, hc_d);
              end
            end
            PRtok: begin
              if (b == 8'hFE) begin bi_d = '0; ph_d = PRdat; end
              nres = 2'd1; r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
            end
            PRdat: begin
              bn = bi_q + 1'b1;
              if (bn >= BiW'(BlockBytes)) begin bi_d = '0; ph_d = PRcrc; end
              else bi_d = bn;
              nres = 2'd2; r0 = mk(KindRd, b, 1'b1, StOk, hc_q);
              r1 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
            end
            PWtok: begin
              bi_d = '0; ph_d = PWneed;
              nres = 2'd1; r0 = mk(KindNeed, 0, 1'b1, StOk, hc_q);
            end
            PWdat: begin
              bn = bi_q + 1'b1; nres = 2'd1;
              if (bn < BiW'(BlockBytes)) begin
                bi_d = bn; ph_d = PWneed; r0 = mk(KindNeed, 0, 1'b1, StOk, hc_q);
              end else begin
                bi_d = '0; ph_d = PWcrc; r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
              end
            end
            PWcrc: begin
              if (bi_q == '0) bi_d = BiW'(1);
              else ph_d = PWresp;
              nres = 2'd1; r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
            end
            PWresp: begin
              nres = 2'd1;
              if (b[4:0] != 5'h05) begin
                ph_d = PWrej; r0 = mk(KindTx, 8'hFF, 1'b0, StOk, hc_q);
              end else begin
                ph_d = PWbusy; r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
              end
            end
            PWrej: begin
              ph_d = PIdle; nres = 2'd1; r0 = mk(KindDone, 0, 0, StRej, hc_q);
            end
            default: ;
          endcase
          // block finished: next block or done
          if ((ph_q == PRcrc && bi_q != '0) || (ph_q == PWbusy && b != 8'h00)) begin
            badr_d = badr_q + 1'b1; bl = blk_q - 1'b1; blk_d = bl; nres = 2'd1;
            ca = hc_q ? badr_d : (badr_d << $clog2(BlockBytes));
            if (bl != 16'd0) begin
              ph_d = (ph_q == PRcrc) ? PRcmd : PWcmd;
              cmd_d = (ph_q == PRcrc) ? 6'd17 : 6'd24;
              arg_d = ca; to_d = 1'b0; rbl_d = 3'd0; poll_d = '0; bi_d = BiW'(1);
              r0 = mk(KindTx, {2'b01, cmd_d}, 1'b1, StOk, hc_q);
            end else begin
              ph_d = PIdle; r0 = mk(KindDone, 0, 0, StOk, hc_q);
            end
          end else if (ph_q == PRcrc) begin
            bi_d = BiW'(1); nres = 2'd1; r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
          end else if (ph_q == PWbusy) begin
            nres = 2'd1; r0 = mk(KindTx, 8'hFF, 1'b1, StOk, hc_q);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= PIdle; cmd_q <= '0; arg_q <= '0; to_q <= 1'b0; bi_q <= '0;
      poll_q <= '0; retry_q <= '0; blk_q <= '0; badr_q <= '0; hc_q <= 1'b0;
      rbl_q <= '0; ctmo_q <= 16'd5000; rlim_q <= 16'd5000;
    end else begin
      ph_q <= ph_d; cmd_q <= cmd_d; arg_q <= arg_d; to_q <= to_d; bi_q <= bi_d;
      poll_q <= poll_d; retry_q <= retry_d; blk_q <= blk_d; badr_q <= badr_d;
      hc_q <= hc_d; rbl_q <= rbl_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegCmdTimeout: ctmo_q <= cfg_data_i;
          RegRetryLimit: rlim_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  assign empty = (ocnt_q == 3'd0);
  assign opop = pop && !empty;
  assign res_o = oq_q[orp_q];
  assign res_last_o = ol_q[orp_q];

  always_ff @(posedge clk_i) begin
    if (nres != 2'd0) begin
      oq_q[owp_q] <= r0;
      ol_q[owp_q] <= (nres == 2'd1);
    end
    if (nres == 2'd2) begin
      oq_q[owp_q + 2'd1] <= r1;
      ol_q[owp_q + 2'd1] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owp_q <= '0; orp_q <= '0; ocnt_q <= '0;
    end else begin
      owp_q <= owp_q + nres;
      if (opop) orp_q <= orp_q + 1'b1;
      ocnt_q <= ocnt_q + 3'(nres) - 3'(opop);
    end
  end

`ifndef NO_ASSERTIONS
  a_ph_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(ph_q)) else $error("phase not one-hot");
  a_oq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= 3'd4) else $error("result queue overflow");
  a_no_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item_take_o |-> nres == 2'd0) else $error("result without item");
`endif
endmodule

// ===== hw/rtl/sd_card_spi_host_engine_core.sv =====
// Top level of the SPI-mode SD card host engine.
// Path: an item goes through the input queue and the sequencer, and its results are registered in the result queue.
// Throughput: one item per cycle while the result queue has room for two words.
// The sequencer step (one byte exchange per item) sets that rate.
// Reset: asynchronous, active low; clears queues, sequencer and both registers to 5000.
module sd_card_spi_host_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  drive_number_i,
  input  logic [31:0] sector_i,
  input  logic [15:0] block_count_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic        card_select_o,
  output logic [2:0]  status_o,
  output logic        high_capacity_o,
  output logic        last_o
);
  import sdspi_pkg::*;

  logic  item_valid, item_take;
  item_t item;
  res_t  res;

  sdspi_front u_front (
    .clk_i, .rst_ni, .push, .full, .operation_i, .drive_number_i, .sector_i,
    .block_count_i, .data_byte_i, .item_valid_o(item_valid), .item_o(item),
    .item_take_i(item_take)
  );

  sdspi_back u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .item_valid_i(item_valid), .item_i(item), .item_take_o(item_take),
    .empty, .pop, .res_o(res), .res_last_o(last_o)
  );

  assign kind_o = res.kind;
  assign byte_value_o = res.value;
  assign card_select_o = res.cs;
  assign status_o = res.status;
  assign high_capacity_o = res.hc;
endmodule
